>>> rtl/eabv_pkg.sv
// Shared types, constants and arithmetic helpers for the Euler angle to basis vector block.
package eabv_pkg;

    localparam int ANGLE_FRAC_BITS = 6;
    localparam int OUT_FRAC_BITS   = 14;
    localparam int CORDIC_STEPS    = 20;
    localparam int ZQ              = 20;
    localparam int DQ              = 30;
    localparam int TURN            = 360 << ANGLE_FRAC_BITS;
    localparam int QUARTER         = 90 << ANGLE_FRAC_BITS;
    localparam int XW              = 34;
    localparam int VW              = 32;
    localparam int SW              = 34;
    localparam logic signed [XW-1:0] CORDIC_X0 = XW'(652032874);

    typedef struct packed {
        logic signed [15:0] pitch_deg;
        logic signed [15:0] yaw_deg;
        logic signed [15:0] roll_deg;
    } t_angles;

    typedef struct packed {
        logic signed [15:0] forward_x;
        logic signed [15:0] forward_y;
        logic signed [15:0] forward_z;
        logic signed [15:0] right_x;
        logic signed [15:0] right_y;
        logic signed [15:0] right_z;
        logic signed [15:0] up_x;
        logic signed [15:0] up_y;
        logic signed [15:0] up_z;
    } t_basis;

    function automatic logic signed [31:0] atan_q20(input int k);
        logic signed [31:0] v;
        unique case (k)
            0:  v = 32'sd47185920;
            1:  v = 32'sd27855475;
            2:  v = 32'sd14718068;
            3:  v = 32'sd7471121;
            4:  v = 32'sd3750058;
            5:  v = 32'sd1876857;
            6:  v = 32'sd938658;
            7:  v = 32'sd469357;
            8:  v = 32'sd234682;
            9:  v = 32'sd117342;
            10: v = 32'sd58671;
            11: v = 32'sd29335;
            12: v = 32'sd14668;
            13: v = 32'sd7334;
            14: v = 32'sd3667;
            15: v = 32'sd1833;
            16: v = 32'sd917;
            17: v = 32'sd458;
            18: v = 32'sd229;
            19: v = 32'sd115;
            default: v = 32'sd0;
        endcase
        return v;
    endfunction

    function automatic logic signed [15:0] to_out(input logic signed [SW-1:0] v);
        logic signed [SW-1:0] t;
        logic signed [SW-1:0] lim;
        t   = (v + SW'(1 << (DQ - OUT_FRAC_BITS - 1))) >>> (DQ - OUT_FRAC_BITS);
        lim = SW'(1 << OUT_FRAC_BITS);
        if (t > lim) begin
            t = lim;
        end else if (t < -lim) begin
            t = -lim;
        end
        return t[15:0];
    endfunction

endpackage

>>> rtl/eabv_reduce.sv
// Angle reduction into a quadrant and a Q20 degree remainder, two register stages.
module eabv_reduce (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic signed [15:0] i_angle,
    output logic               o_valid,
    output logic [1:0]         o_quad,
    output logic signed [31:0] o_z
);
    import eabv_pkg::*;

    logic               r_v1;
    logic [14:0]        r_m;
    logic               r_v2;
    logic [1:0]         r_quad;
    logic signed [31:0] r_z;
    logic signed [17:0] a;
    logic signed [17:0] n_m;
    logic [1:0]         n_quad;
    logic [14:0]        n_r;

    assign a = 18'(i_angle);

    always_comb begin
        priority if (a < -18'sd23040) begin
            n_m = a + 18'(2 * TURN);
        end else if (a < 18'sd0) begin
            n_m = a + 18'(TURN);
        end else if (a >= 18'(TURN)) begin
            n_m = a - 18'(TURN);
        end else begin
            n_m = a;
        end
    end

    always_comb begin
        priority if (r_m < 15'(QUARTER)) begin
            n_quad = 2'd0;
            n_r    = r_m;
        end else if (r_m < 15'(2 * QUARTER)) begin
            n_quad = 2'd1;
            n_r    = r_m - 15'(QUARTER);
        end else if (r_m < 15'(3 * QUARTER)) begin
            n_quad = 2'd2;
            n_r    = r_m - 15'(2 * QUARTER);
        end else begin
            n_quad = 2'd3;
            n_r    = r_m - 15'(3 * QUARTER);
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_v1 <= 1'b0;
            r_v2 <= 1'b0;
        end else begin
            r_v1 <= i_valid;
            r_v2 <= r_v1;
        end
        r_m    <= n_m[14:0];
        r_quad <= n_quad;
        r_z    <= 32'(n_r) <<< (ZQ - ANGLE_FRAC_BITS);
    end

    assign o_valid = r_v2;
    assign o_quad  = r_quad;
    assign o_z     = r_z;
endmodule

>>> rtl/eabv_cordic.sv
// Pipelined rotation CORDIC, one iteration per stage, with quadrant folding at the end.
module eabv_cordic (
    input  logic               i_clk,
    input  logic               i_rst_n,
    input  logic               i_valid,
    input  logic [1:0]         i_quad,
    input  logic signed [31:0] i_z,
    output logic               o_valid,
    output logic signed [31:0] o_sin,
    output logic signed [31:0] o_cos
);
    import eabv_pkg::*;

    logic signed [XW-1:0] r_x [CORDIC_STEPS];
    logic signed [XW-1:0] r_y [CORDIC_STEPS];
    logic signed [31:0]   r_zs [CORDIC_STEPS];
    logic [1:0]           r_q [CORDIC_STEPS];
    logic                 r_v [CORDIC_STEPS];
    logic                 r_vo;
    logic signed [31:0]   r_sin;
    logic signed [31:0]   r_cos;

    genvar k;
    generate
        for (k = 0; k < CORDIC_STEPS; k++) begin : g_step
            logic signed [XW-1:0] px;
            logic signed [XW-1:0] py;
            logic signed [31:0]   pz;
            logic [1:0]           pq;
            logic                 pv;
            if (k == 0) begin : g_first
                assign px = CORDIC_X0;
                assign py = '0;
                assign pz = i_z;
                assign pq = i_quad;
                assign pv = i_valid;
            end else begin : g_next
                assign px = r_x[k-1];
                assign py = r_y[k-1];
                assign pz = r_zs[k-1];
                assign pq = r_q[k-1];
                assign pv = r_v[k-1];
            end
            always_ff @(posedge i_clk) begin
                if (!i_rst_n) begin
                    r_v[k] <= 1'b0;
                end else begin
                    r_v[k] <= pv;
                end
                if (pz >= 0) begin
                    r_x[k]  <= px - (py >>> k);
                    r_y[k]  <= py + (px >>> k);
                    r_zs[k] <= pz - atan_q20(k);
                end else begin
                    r_x[k]  <= px + (py >>> k);
                    r_y[k]  <= py - (px >>> k);
                    r_zs[k] <= pz + atan_q20(k);
                end
                r_q[k] <= pq;
            end
        end
    endgenerate

    logic signed [XW-1:0] fx;
    logic signed [XW-1:0] fy;
    assign fx = r_x[CORDIC_STEPS-1];
    assign fy = r_y[CORDIC_STEPS-1];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vo <= 1'b0;
        end else begin
            r_vo <= r_v[CORDIC_STEPS-1];
        end
        unique case (r_q[CORDIC_STEPS-1])
            2'd0: begin
                r_cos <= fx[31:0];
                r_sin <= fy[31:0];
            end
            2'd1: begin
                r_cos <= -fy[31:0];
                r_sin <= fx[31:0];
            end
            2'd2: begin
                r_cos <= -fx[31:0];
                r_sin <= -fy[31:0];
            end
            default: begin
                r_cos <= fy[31:0];
                r_sin <= -fx[31:0];
            end
        endcase
    end

    assign o_valid = r_vo;
    assign o_sin   = r_sin;
    assign o_cos   = r_cos;
endmodule

>>> rtl/eabv_qmul.sv
// Q30 fixed-point multiplier with round half up, product and rounding in two stages.
module eabv_qmul (
    input  logic               i_clk,
    input  logic signed [31:0] i_a,
    input  logic signed [31:0] i_b,
    output logic signed [31:0] o_p
);
    import eabv_pkg::*;

    logic signed [63:0] r_prod;
    logic signed [31:0] r_p;
    logic signed [63:0] rnd;

    assign rnd = (r_prod + 64'sd536870912) >>> DQ;

    always_ff @(posedge i_clk) begin
        r_prod <= i_a * i_b;
        r_p    <= rnd[31:0];
    end

    assign o_p = r_p;
endmodule

>>> rtl/euler_angles_to_basis_vectors.sv
// Top level: converts pitch, yaw and roll into forward, right and up unit vectors.
// Throughput is one request per cycle; busy is never asserted.
// Reduction takes 2 stages, the CORDIC 21, two multiply levels 4, sum and output 2.
// Synchronous active-low reset clears only the valid bits, so requests in flight are dropped.
module euler_angles_to_basis_vectors (
    input  logic                   i_clk,
    input  logic                   i_rst_n,
    input  logic                   start,
    output logic                   busy,
    input  eabv_pkg::t_angles      i_req,
    output logic                   o_result_valid,
    output eabv_pkg::t_basis       o_result
);
    import eabv_pkg::*;

    logic               acc;
    logic [2:0]         red_v;
    logic [1:0]         red_q [3];
    logic signed [31:0] red_z [3];
    logic [2:0]         cor_v;
    logic signed [31:0] sn [3];
    logic signed [31:0] cs [3];
    logic signed [15:0] ang [3];

    assign busy = 1'b0;
    assign acc  = start & ~busy;
    assign ang[0] = i_req.pitch_deg;
    assign ang[1] = i_req.yaw_deg;
    assign ang[2] = i_req.roll_deg;

    genvar g;
    generate
        for (g = 0; g < 3; g++) begin : g_axis
            eabv_reduce u_reduce (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (acc),
                .i_angle (ang[g]),
                .o_valid (red_v[g]),
                .o_quad  (red_q[g]),
                .o_z     (red_z[g])
            );
            eabv_cordic u_cordic (
                .i_clk   (i_clk),
                .i_rst_n (i_rst_n),
                .i_valid (red_v[g]),
                .i_quad  (red_q[g]),
                .i_z     (red_z[g]),
                .o_valid (cor_v[g]),
                .o_sin   (sn[g]),
                .o_cos   (cs[g])
            );
        end
    endgenerate

    logic signed [31:0] sp, cp, sy, cy, sr, cr;
    assign sp = sn[0];
    assign cp = cs[0];
    assign sy = sn[1];
    assign cy = cs[1];
    assign sr = sn[2];
    assign cr = cs[2];

    // First multiply level.
    logic signed [31:0] srsp, crsp, cpcy, cpsy, crsy, crcy, srcp, srsy, srcy, crcp;
    eabv_qmul u_m_srsp (.i_clk(i_clk), .i_a(sr), .i_b(sp), .o_p(srsp));
    eabv_qmul u_m_crsp (.i_clk(i_clk), .i_a(cr), .i_b(sp), .o_p(crsp));
    eabv_qmul u_m_cpcy (.i_clk(i_clk), .i_a(cp), .i_b(cy), .o_p(cpcy));
    eabv_qmul u_m_cpsy (.i_clk(i_clk), .i_a(cp), .i_b(sy), .o_p(cpsy));
    eabv_qmul u_m_crsy (.i_clk(i_clk), .i_a(cr), .i_b(sy), .o_p(crsy));
    eabv_qmul u_m_crcy (.i_clk(i_clk), .i_a(cr), .i_b(cy), .o_p(crcy));
    eabv_qmul u_m_srcp (.i_clk(i_clk), .i_a(sr), .i_b(cp), .o_p(srcp));
    eabv_qmul u_m_srsy (.i_clk(i_clk), .i_a(sr), .i_b(sy), .o_p(srsy));
    eabv_qmul u_m_srcy (.i_clk(i_clk), .i_a(sr), .i_b(cy), .o_p(srcy));
    eabv_qmul u_m_crcp (.i_clk(i_clk), .i_a(cr), .i_b(cp), .o_p(crcp));

    logic signed [31:0] r_cy_d [2];
    logic signed [31:0] r_sy_d [2];
    logic signed [31:0] r_sp_d [4];

    // Second multiply level.
    logic signed [31:0] a_rx, a_ry, a_ux, a_uy;
    eabv_qmul u_m_rx (.i_clk(i_clk), .i_a(srsp), .i_b(r_cy_d[1]), .o_p(a_rx));
    eabv_qmul u_m_ry (.i_clk(i_clk), .i_a(srsp), .i_b(r_sy_d[1]), .o_p(a_ry));
    eabv_qmul u_m_ux (.i_clk(i_clk), .i_a(crsp), .i_b(r_cy_d[1]), .o_p(a_ux));
    eabv_qmul u_m_uy (.i_clk(i_clk), .i_a(crsp), .i_b(r_sy_d[1]), .o_p(a_uy));

    logic signed [31:0] r_cpcy [2], r_cpsy [2], r_crsy [2], r_crcy [2];
    logic signed [31:0] r_srcp [2], r_srsy [2], r_srcy [2], r_crcp [2];
    logic signed [SW-1:0] r_sum [9];
    t_basis             r_out;
    logic [5:0]         r_valid_pipe;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid_pipe <= '0;
        end else begin
            r_valid_pipe <= {r_valid_pipe[4:0], cor_v[0]};
        end
        r_cy_d[0] <= cy;
        r_cy_d[1] <= r_cy_d[0];
        r_sy_d[0] <= sy;
        r_sy_d[1] <= r_sy_d[0];
        r_sp_d[0] <= sp;
        r_sp_d[1] <= r_sp_d[0];
        r_sp_d[2] <= r_sp_d[1];
        r_sp_d[3] <= r_sp_d[2];
        r_cpcy[0] <= cpcy;
        r_cpcy[1] <= r_cpcy[0];
        r_cpsy[0] <= cpsy;
        r_cpsy[1] <= r_cpsy[0];
        r_crsy[0] <= crsy;
        r_crsy[1] <= r_crsy[0];
        r_crcy[0] <= crcy;
        r_crcy[1] <= r_crcy[0];
        r_srcp[0] <= srcp;
        r_srcp[1] <= r_srcp[0];
        r_srsy[0] <= srsy;
        r_srsy[1] <= r_srsy[0];
        r_srcy[0] <= srcy;
        r_srcy[1] <= r_srcy[0];
        r_crcp[0] <= crcp;
        r_crcp[1] <= r_crcp[0];

        r_sum[0] <= SW'(r_cpcy[1]);
        r_sum[1] <= SW'(r_cpsy[1]);
        r_sum[2] <= -SW'(r_sp_d[3]);
        r_sum[3] <= SW'(r_crsy[1]) - SW'(a_rx);
        r_sum[4] <= -SW'(a_ry) - SW'(r_crcy[1]);
        r_sum[5] <= -SW'(r_srcp[1]);
        r_sum[6] <= SW'(a_ux) + SW'(r_srsy[1]);
        r_sum[7] <= SW'(a_uy) - SW'(r_srcy[1]);
        r_sum[8] <= SW'(r_crcp[1]);

        r_out.forward_x <= to_out(r_sum[0]);
        r_out.forward_y <= to_out(r_sum[1]);
        r_out.forward_z <= to_out(r_sum[2]);
        r_out.right_x   <= to_out(r_sum[3]);
        r_out.right_y   <= to_out(r_sum[4]);
        r_out.right_z   <= to_out(r_sum[5]);
        r_out.up_x      <= to_out(r_sum[6]);
        r_out.up_y      <= to_out(r_sum[7]);
        r_out.up_z      <= to_out(r_sum[8]);
    end

    assign o_result_valid = r_valid_pipe[5];
    assign o_result       = r_out;
endmodule
